### sv/psrb_pkg.sv
// ----------------------------------------------------------------------------
// psrb_pkg
// shared types and constants for the packet sequence reorder buffer: input and
// result descriptors, held entry layout and the store command/status bundles
// ----------------------------------------------------------------------------
package psrb_pkg;

    localparam int SEQ_W       = 16;
    localparam int TAG_W       = 16;
    localparam int LEN_W       = 16;
    localparam int LIMIT_W     = 5;
    localparam int MAX_RESULTS = 16;
    localparam int NCNT_W      = 5;

    localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RESET = 5'd10;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_number;
        logic             has_payload;
        logic [TAG_W-1:0] payload_tag;
        logic [LEN_W-1:0] payload_length;
    } pkt_in_t;

    typedef struct packed {
        logic [TAG_W-1:0] out_tag;
        logic [LEN_W-1:0] out_length;
        logic [SEQ_W-1:0] out_seq;
        logic             last_of_run;
    } pkt_out_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] length;
    } entry_t;

    typedef struct packed {
        logic scan;
        logic write;
        logic clear;
    } store_cmd_t;

    typedef struct packed {
        logic   done;
        logic   min_found;
        entry_t min_entry;
    } store_stat_t;

endpackage

### sv/psrb_store.sv
// ----------------------------------------------------------------------------
// psrb_store
// held packet store: one synchronous memory plus per-entry valid bits and a
// scan engine that walks every entry to find the lowest held sequence and an
// entry with a matching key
// ----------------------------------------------------------------------------
module psrb_store
    import psrb_pkg::*;
#(
    parameter int STORE_DEPTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  store_cmd_t                         cmd,
    input  logic [SEQ_W-1:0]                   key,
    input  entry_t                             wr_data,
    output store_stat_t                        stat,
    output logic [$clog2(STORE_DEPTH+1)-1:0]   count
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(STORE_DEPTH - 1);

    entry_t                 mem [STORE_DEPTH];
    entry_t                 rd_data_reg;

    logic [STORE_DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   scan_active_reg, scan_active_next;
    logic [IW-1:0]          addr_reg, addr_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [IW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   done_reg, done_next;
    logic [SEQ_W-1:0]       key_reg, key_next;
    logic                   min_found_reg, min_found_next;
    entry_t                 min_reg, min_next;
    logic [IW-1:0]          min_idx_reg, min_idx_next;
    logic                   match_found_reg, match_found_next;
    logic [IW-1:0]          match_idx_reg, match_idx_next;

    logic                   free_found;
    logic [IW-1:0]          free_idx;
    logic [IW-1:0]          wr_idx;
    logic                   wr_ok;
    logic                   hit_valid;
    logic                   take_min;
    logic                   take_match;

    // lowest free entry
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = STORE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign wr_idx = match_found_reg ? match_idx_reg : free_idx;
    assign wr_ok  = cmd.write && (match_found_reg || free_found);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    assign hit_valid  = rd_pend_reg && valid_reg[rd_idx_reg];
    assign take_min   = hit_valid && (!min_found_reg || (rd_data_reg.seq < min_reg.seq));
    assign take_match = hit_valid && (rd_data_reg.seq == key_reg);

    always_comb
    begin
        valid_next       = valid_reg;
        count_next       = count_reg;
        scan_active_next = scan_active_reg;
        addr_next        = addr_reg;
        rd_pend_next     = scan_active_reg;
        rd_idx_next      = addr_reg;
        done_next        = rd_pend_reg && (rd_idx_reg == LAST_IDX);
        key_next         = key_reg;
        min_found_next   = min_found_reg;
        min_next         = min_reg;
        min_idx_next     = min_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;

        // compare the entry read last cycle
        if (take_min)
        begin
            min_found_next = 1'b1;
            min_next       = rd_data_reg;
            min_idx_next   = rd_idx_reg;
        end
        if (take_match)
        begin
            match_found_next = 1'b1;
            match_idx_next   = rd_idx_reg;
        end

        if (scan_active_reg)
        begin
            if (addr_reg == LAST_IDX)
            begin
                scan_active_next = 1'b0;
                addr_next        = '0;
            end
            else
            begin
                addr_next = addr_reg + 1'b1;
            end
        end

        if (cmd.scan)
        begin
            scan_active_next = 1'b1;
            addr_next        = '0;
            key_next         = key;
            min_found_next   = 1'b0;
            match_found_next = 1'b0;
        end

        if (wr_ok)
        begin
            valid_next[wr_idx] = 1'b1;
            if (!match_found_reg)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (cmd.clear)
        begin
            valid_next[min_idx_reg] = 1'b0;
            count_next              = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            count_reg       <= '0;
            scan_active_reg <= 1'b0;
            addr_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            rd_idx_reg      <= '0;
            done_reg        <= 1'b0;
            min_found_reg   <= 1'b0;
            match_found_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            count_reg       <= count_next;
            scan_active_reg <= scan_active_next;
            addr_reg        <= addr_next;
            rd_pend_reg     <= rd_pend_next;
            rd_idx_reg      <= rd_idx_next;
            done_reg        <= done_next;
            min_found_reg   <= min_found_next;
            match_found_reg <= match_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        min_reg       <= min_next;
        min_idx_reg   <= min_idx_next;
        match_idx_reg <= match_idx_next;
    end

    assign stat.done      = done_reg;
    assign stat.min_found = min_found_reg;
    assign stat.min_entry = min_reg;
    assign count          = count_reg;

endmodule

### sv/packet_sequence_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// packet_sequence_reorder_buffer_core
// reorders received packet descriptors by sequence number, holding early
// packets in a small store and releasing them in order
// ----------------------------------------------------------------------------
// one packet descriptor is taken per start while busy is low; the block then
// stays busy until every delivery caused by that packet has gone out. results
// appear one per cycle at most, each for exactly one cycle with result_strobe
// high, and the receiver cannot hold them off; last_of_run marks the final
// delivery of the packet. a dropped packet (empty, zero length, or nonzero and
// older than the last delivered seq) keeps busy low and gives no result. every
// search of the store is a full pass over the held packet memory through its
// single read port. hold_limit is written through cfg_valid / cfg_ready,
// accepted only while busy is low, and resets to 10.
module packet_sequence_reorder_buffer_core
    import psrb_pkg::*;
#(
    parameter int STORE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // packet transfer
    input  logic               start,
    output logic               busy,
    input  pkt_in_t            pkt,
    // delivery transfer
    output logic               result_strobe,
    output pkt_out_t           result,
    // hold limit register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int CW     = $clog2(STORE_DEPTH + 1);
    localparam int LW     = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int LimCap = (STORE_DEPTH < MAX_RESULTS) ? STORE_DEPTH : MAX_RESULTS;
    localparam logic [LIMIT_W-1:0] LIM_CAP = LIMIT_W'(LimCap);

    // sequencer states
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_FLUSH      = 4'd1;
    localparam logic [3:0] S_FLUSH_WAIT = 4'd2;
    localparam logic [3:0] S_PLACE      = 4'd3;
    localparam logic [3:0] S_HOLD_WAIT  = 4'd4;
    localparam logic [3:0] S_REL        = 4'd5;
    localparam logic [3:0] S_REL_WAIT   = 4'd6;
    localparam logic [3:0] S_REL_NEXT   = 4'd7;
    localparam logic [3:0] S_FINISH     = 4'd8;

    localparam logic [NCNT_W-1:0] FLUSH_CAP = NCNT_W'(MAX_RESULTS - 1);
    localparam logic [NCNT_W-1:0] RUN_CAP   = NCNT_W'(MAX_RESULTS);

    logic [3:0]         state_reg, state_next;
    pkt_in_t            item_reg, item_next;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [NCNT_W-1:0]  n_reg, n_next;
    logic               jump_reg, jump_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;

    // one-deep holding slot so the final delivery can carry last_of_run
    logic               pend_valid_reg, pend_valid_next;
    entry_t             pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    pkt_out_t           out_reg, out_next;

    store_cmd_t         cmd;
    store_stat_t        stat;
    logic [CW-1:0]      count;
    entry_t             item_entry;

    logic               push_en;
    entry_t             push_entry;
    logic               finish_en;

    logic               drop;
    logic [SEQ_W:0]     base_inc;
    logic [SEQ_W:0]     eff_inc;
    logic [SEQ_W-1:0]   eff_base;
    logic [LIMIT_W-1:0] lim_eff;
    logic               at_limit;

    assign item_entry = '{seq: item_reg.seq_number, tag: item_reg.payload_tag,
                          length: item_reg.payload_length};

    psrb_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .key     (item_reg.seq_number),
        .wr_data (item_entry),
        .stat    (stat),
        .count   (count)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // sequences compare unsigned with one extra bit, no wrap
    assign base_inc = {1'b0, base_reg} + 17'd1;
    assign eff_base = jump_reg ? stat.min_entry.seq : base_reg;
    assign eff_inc  = {1'b0, eff_base} + 17'd1;

    assign drop = !pkt.has_payload || (pkt.payload_length == '0) ||
                  ((pkt.seq_number != '0) && (pkt.seq_number < base_reg));

    // hold limit saturates at the store depth and the per-packet result cap
    assign lim_eff  = (limit_reg > LIM_CAP) ? LIM_CAP : limit_reg;
    assign at_limit = (LW'(count) >= LW'(lim_eff));

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end
    end

    // main sequencer
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        base_next  = base_reg;
        n_next     = n_reg;
        jump_next  = jump_reg;
        cmd        = '0;
        push_en    = 1'b0;
        push_entry = stat.min_entry;
        finish_en  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = pkt;
                    n_next    = '0;
                    if (!drop)
                    begin
                        state_next = (pkt.seq_number == '0) ? S_FLUSH : S_PLACE;
                    end
                end
            end

            // sequence zero empties the store in ascending order, delivering at most FLUSH_CAP of its entries
            S_FLUSH:
            begin
                if (count == '0)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.scan   = 1'b1;
                    state_next = S_FLUSH_WAIT;
                end
            end

            S_FLUSH_WAIT:
            begin
                if (stat.done)
                begin
                    if (n_reg < FLUSH_CAP)
                    begin
                        push_en = 1'b1;
                        n_next  = n_reg + 1'b1;
                    end
                    cmd.clear  = 1'b1;
                    state_next = S_FLUSH;
                end
            end

            // deliver now, hold for later, or drop a repeat of the base
            S_PLACE:
            begin
                if ((base_reg == '0) || (item_reg.seq_number == '0) ||
                    ({1'b0, item_reg.seq_number} == base_inc))
                begin
                    push_en    = 1'b1;
                    push_entry = item_entry;
                    n_next     = n_reg + 1'b1;
                    base_next  = item_reg.seq_number;
                    state_next = S_REL;
                end
                else if ({1'b0, item_reg.seq_number} > base_inc)
                begin
                    cmd.scan   = 1'b1;
                    state_next = S_HOLD_WAIT;
                end
                else
                begin
                    state_next = S_REL;
                end
            end

            // duplicate key overwrites, otherwise lowest free entry
            S_HOLD_WAIT:
            begin
                if (stat.done)
                begin
                    cmd.write  = 1'b1;
                    state_next = S_REL;
                end
            end

            S_REL:
            begin
                if (count == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    jump_next  = at_limit;
                    cmd.scan   = 1'b1;
                    state_next = S_REL_WAIT;
                end
            end

            // release the lowest held packet while it continues the run or the hold limit is hit
            S_REL_WAIT:
            begin
                if (stat.done)
                begin
                    jump_next = 1'b0;
                    if (stat.min_found && ({1'b0, stat.min_entry.seq} <= eff_inc) &&
                        (n_reg < RUN_CAP))
                    begin
                        push_en    = 1'b1;
                        n_next     = n_reg + 1'b1;
                        base_next  = stat.min_entry.seq;
                        cmd.clear  = 1'b1;
                        state_next = S_REL_NEXT;
                    end
                    else
                    begin
                        base_next  = eff_base;
                        state_next = S_FINISH;
                    end
                end
            end

            S_REL_NEXT:
            begin
                if (count == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan   = 1'b1;
                    state_next = S_REL_WAIT;
                end
            end

            S_FINISH:
            begin
                finish_en  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result staging: a new delivery pushes the waiting one out
    always_comb
    begin
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        if (push_en)
        begin
            if (pend_valid_reg)
            begin
                out_next       = '{out_tag: pend_reg.tag, out_length: pend_reg.length,
                                   out_seq: pend_reg.seq, last_of_run: 1'b0};
                out_valid_next = 1'b1;
            end
            pend_next       = push_entry;
            pend_valid_next = 1'b1;
        end
        else if (finish_en && pend_valid_reg)
        begin
            out_next        = '{out_tag: pend_reg.tag, out_length: pend_reg.length,
                                out_seq: pend_reg.seq, last_of_run: 1'b1};
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= '0;
            n_reg          <= '0;
            jump_reg       <= 1'b0;
            limit_reg      <= HOLD_LIMIT_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            n_reg          <= n_next;
            jump_reg       <= jump_next;
            limit_reg      <= limit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign result_strobe = out_valid_reg;
    assign result        = out_reg;

endmodule
